[design/set_assoc_lru_cache_model_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache core
// Shared helpers for concurrent checks on a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SALC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Types, codes and constants shared by the set-associative LRU cache core.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // Fixed field widths
  localparam int ADDR_IN_W   = 64;
  localparam int MODE_W      = 2;
  localparam int SETB_CFG_W  = 3;
  localparam int WAYS_CFG_W  = 4;
  localparam int OFFS_CFG_W  = 6;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int TOTAL_W     = 32;
  localparam int SBITS_W     = 4;   // holds a set bit count up to 12
  localparam int WAYS_CNT_W  = 5;   // holds a way count up to 16
  localparam int SHAMT_W     = 7;   // offset plus set bits, up to 75
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_FETCH  = 2'd3
  } salc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_INDEX_BITS = 2'd0,
    REG_WAYS_IN_USE    = 2'd1,
    REG_OFFSET_BITS    = 2'd2
  } salc_reg_e;

  typedef struct packed {
    logic [SETB_CFG_W-1:0] set_index_bits;
    logic [WAYS_CFG_W-1:0] ways_in_use;
    logic [OFFS_CFG_W-1:0] offset_bits;
  } salc_cfg_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic eviction;
    logic last;
  } salc_result_t;

endpackage

[design/salc_ram.sv]
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/salc_front.sv]
// ----------------------------------------------------------------------------
// salc_front
// Accepts transactions, splits the address into set and tag and queues one
// access per load or store, two per modify, none per instruction fetch.
// ----------------------------------------------------------------------------
module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int ENTRY_W = 1 + SET_W + ADDR_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [salc_pkg::ADDR_IN_W-1:0]    address_i,
  input  logic [salc_pkg::MODE_W-1:0]       mode_i,
  input  salc_pkg::salc_cfg_t               cfg_i,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [ENTRY_W-1:0]                push_data_o
);

  import salc_pkg::*;

  logic                  pend_q;
  logic [ENTRY_W-1:0]    pend_entry_q;
  logic                  accept;
  logic [SBITS_W-1:0]    sbits;
  logic [ADDR_WIDTH-1:0] addr_m;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_idx;
  logic [SHAMT_W-1:0]    tag_amt;
  logic [ADDR_WIDTH-1:0] tag;

  always_comb begin
    sbits = (SBITS_W'(cfg_i.set_index_bits) > SBITS_W'(MAX_SET_BITS)) ?
            SBITS_W'(MAX_SET_BITS) : SBITS_W'(cfg_i.set_index_bits);
    addr_m   = address_i[ADDR_WIDTH-1:0];
    shifted  = addr_m >> cfg_i.offset_bits;
    set_mask = ~({SET_W{1'b1}} << sbits);
    set_idx  = shifted[SET_W-1:0] & set_mask;
    tag_amt  = SHAMT_W'(cfg_i.offset_bits) + SHAMT_W'(sbits);
    tag      = addr_m >> tag_amt;
  end

  // Hold off while the second half of a modify waits or the queue is full
  assign busy   = pend_q || full_i;
  assign accept = start && !busy;

  assign push_o      = (pend_q && !full_i) || (accept && (mode_i != MODE_FETCH));
  assign push_data_o = pend_q ? pend_entry_q
                              : {(mode_i != MODE_MODIFY), set_idx, tag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (pend_q) begin
      if (!full_i) begin
        pend_q <= 1'b0;
      end
    end else if (accept && (mode_i == MODE_MODIFY)) begin
      pend_q <= 1'b1;
    end
  end

  // The store half of a modify closes the transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_entry_q <= {1'b1, set_idx, tag};
    end
  end

endmodule

[design/salc_fifo.sv]
// ----------------------------------------------------------------------------
// salc_fifo
// Short access queue between the front and the back.
// ----------------------------------------------------------------------------
module salc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/salc_back.sv]
// ----------------------------------------------------------------------------
// salc_back
// Executes queued accesses: reads a set's row, looks up the tag, updates
// valid bits, tags and ages, writes the row back and reports the outcome.
// ----------------------------------------------------------------------------
module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int ENTRY_W  = 1 + SET_W + ADDR_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  salc_pkg::salc_cfg_t               cfg_i,
  input  logic                              empty_i,
  input  logic [ENTRY_W-1:0]                entry_i,
  output logic                              pop_o,
  output logic                              done_o,
  output salc_pkg::salc_result_t            res_o,
  output logic [salc_pkg::TOTAL_W-1:0]      total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0]      total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0]      total_evictions_o
);

  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WIDX_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W    = MAX_WAYS * WAY_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                state_q;
  logic [NUM_SETS-1:0]   row_valid_q;
  logic                  rv_q;
  logic                  done_q;
  salc_result_t          res_q;
  logic [TOTAL_W-1:0]    hits_q;
  logic [TOTAL_W-1:0]    misses_q;
  logic [TOTAL_W-1:0]    evicts_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                  last_q;

  logic [SET_W-1:0]      head_set;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      new_row;
  logic                  ram_we;
  logic [WAYS_CNT_W-1:0] ways_eff;
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   way_v;
  logic [AGE_W-1:0]      way_age [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
  logic                  found;
  logic [WIDX_W-1:0]     found_idx;
  logic                  empty_found;
  logic [WIDX_W-1:0]     empty_idx;
  logic [WIDX_W-1:0]     victim;
  logic [AGE_W-1:0]      victim_age;
  logic [AGE_W-1:0]      hit_age;
  logic [WIDX_W-1:0]     tgt;
  logic                  evict;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == TOTAL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a >= AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

  assign head_set = entry_i[ADDR_WIDTH +: SET_W];
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign ram_we   = (state_q == ST_LOOKUP);

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (new_row),
    .re_i    (pop_o),
    .raddr_i (head_set),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ways_eff = (cfg_i.ways_in_use == '0) ? WAYS_CNT_W'(1) :
               ((WAYS_CNT_W'(cfg_i.ways_in_use) > WAYS_CNT_W'(MAX_WAYS)) ?
                WAYS_CNT_W'(MAX_WAYS) : WAYS_CNT_W'(cfg_i.ways_in_use));
    // A row never written reads as all lines invalid with age zero
    row = rv_q ? ram_rdata : '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = (WAYS_CNT_W'(w) < ways_eff);
      way_v[w]   = row[w*WAY_W + WAY_W - 1];
      way_age[w] = row[w*WAY_W + ADDR_WIDTH +: AGE_W];
      way_tag[w] = row[w*WAY_W +: ADDR_WIDTH];
    end
  end

  // Search the set: first matching way, first empty way, oldest way
  always_comb begin
    found       = 1'b0;
    found_idx   = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    victim      = '0;
    victim_age  = way_age[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w]) begin
        if (way_v[w] && (way_tag[w] == tag_q) && !found) begin
          found     = 1'b1;
          found_idx = WIDX_W'(w);
        end
        if (!way_v[w] && !empty_found) begin
          empty_found = 1'b1;
          empty_idx   = WIDX_W'(w);
        end
        if (way_age[w] > victim_age) begin
          victim     = WIDX_W'(w);
          victim_age = way_age[w];
        end
      end
    end
  end

  // Accessed line to rank zero; age other valid lines (on a hit, newer ones)
  always_comb begin
    hit_age = way_age[found_idx];
    tgt     = found ? found_idx : (empty_found ? empty_idx : victim);
    evict   = !found && !empty_found;
    new_row = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w]) begin
        if (WIDX_W'(w) == tgt) begin
          new_row[w*WAY_W +: WAY_W] = {1'b1, {AGE_W{1'b0}}, tag_q};
        end else if (way_v[w] && (!found || (way_age[w] < hit_age))) begin
          new_row[w*WAY_W + ADDR_WIDTH +: AGE_W] = age_inc(way_age[w]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      rv_q        <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      done_q <= (state_q == ST_LOOKUP);
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            rv_q    <= row_valid_q[head_set];
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          row_valid_q[set_q] <= 1'b1;
          res_q              <= '{hit: found, miss: !found, eviction: evict,
                                  last: last_q};
          if (found) begin
            hits_q <= sat_inc(hits_q);
          end else begin
            misses_q <= sat_inc(misses_q);
          end
          if (evict) begin
            evicts_q <= sat_inc(evicts_q);
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_q  <= entry_i[ADDR_WIDTH-1:0];
      set_q  <= head_set;
      last_q <= entry_i[ENTRY_W-1];
    end
  end

  assign done_o            = done_q;
  assign res_o             = res_q;
  assign total_hits_o      = hits_q;
  assign total_misses_o    = misses_q;
  assign total_evictions_o = evicts_q;

endmodule

[design/set_assoc_lru_cache_model_core.sv]
// A load or store is reported by the result strobe after it passes the access queue,
// the row RAM read and the registered lookup. The back takes one cache access at a time,
// reading a set row and writing it back; a modify makes two accesses, a fetch none.
// Up to two accesses queue between front and back; busy rises when the queue is full.
// Reset (asynchronous, active low) clears row valid bits, totals and control state
// and restores the registers to 4, 1 and 4 at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_core
// Set-associative cache lookup with true LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_core_defines.svh"

module set_assoc_lru_cache_model_core #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Transaction handshake: accepted when start is high and busy is low
  input  logic                            start,
  output logic                            busy,
  input  logic [salc_pkg::ADDR_IN_W-1:0]  address_i,
  input  logic [salc_pkg::MODE_W-1:0]     mode_i,
  // Register write port
  input  logic                            cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Results, each valid for the single cycle that done_o is high
  output logic                            done_o,
  output logic                            hit_o,
  output logic                            miss_o,
  output logic                            eviction_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_evictions_o,
  output logic                            last_of_item_o
);

  import salc_pkg::*;

  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENTRY_W = 1 + SET_W + ADDR_WIDTH;

  salc_cfg_t          cfg_q;
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_full;
  logic               q_empty;
  salc_result_t       res;

  // Configuration registers; writes must arrive only while the core is idle, which the
  // block itself does not enforce. Indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_index_bits <= SETB_CFG_W'(4);
      cfg_q.ways_in_use    <= WAYS_CFG_W'(1);
      cfg_q.offset_bits    <= OFFS_CFG_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SET_INDEX_BITS: cfg_q.set_index_bits <= cfg_wdata_i[SETB_CFG_W-1:0];
        REG_WAYS_IN_USE:    cfg_q.ways_in_use    <= cfg_wdata_i[WAYS_CFG_W-1:0];
        REG_OFFSET_BITS:    cfg_q.offset_bits    <= cfg_wdata_i[OFFS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept transactions, derive set and tag, expand modify into
  // a load access followed by a store access, drop instruction fetches.
  salc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .address_i   (address_i),
    .mode_i      (mode_i),
    .cfg_i       (cfg_q),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  // Access queue: lets the front keep taking transactions while the back
  // is busy with a read-modify-write of a set row.
  salc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: one access at a time; it reads the row, then updates and
  // writes it back while the outcome and totals are registered.
  salc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (q_empty),
    .entry_i           (q_rdata),
    .pop_o             (q_pop),
    .done_o            (done_o),
    .res_o             (res),
    .total_hits_o      (total_hits_o),
    .total_misses_o    (total_misses_o),
    .total_evictions_o (total_evictions_o)
  );

  assign hit_o          = res.hit;
  assign miss_o         = res.miss;
  assign eviction_o     = res.eviction;
  assign last_of_item_o = res.last;

  // Every access is exactly one of hit or miss
  `SALC_ASSERT_SAME(a_one_outcome, clk_i, rst_ni, done_o, hit_o != miss_o, "hit and miss clash")
  // An eviction only comes with a miss
  `SALC_ASSERT_SAME(a_evict_on_miss, clk_i, rst_ni, done_o && eviction_o, miss_o, "eviction on hit")
  // The back returns to idle after each access, so strobes never abut
  `SALC_ASSERT_NEXT(a_strobe_gap, clk_i, rst_ni, done_o, !done_o, "back-to-back result strobes")

endmodule

[tb/set_assoc_lru_cache_model_core_test.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_core_test
// Self-checking bench for the set-associative LRU cache core. A clocked
// driver issues accesses and register writes from a planned queue in random
// bursts. A cycle-free cache model in the bench predicts the hit, miss and
// eviction flags and the running totals for each accepted access. A monitor
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_core_test;
  import salc_pkg::*;

  localparam int SET_CAP        = MAX_SET_BITS_DEF;
  localparam int WAY_CAP        = MAX_WAYS_DEF;
  localparam int LINE_COUNT     = (1 << SET_CAP) * WAY_CAP;
  localparam int ACCESS_TARGET  = 800;
  localparam int SETTLE_CYCLES  = 8;    // outlasts the result latency
  localparam int WATCHDOG_LIMIT = 500;

  typedef enum logic [1:0] {
    PLAN_ACCESS,
    PLAN_REG_WRITE,
    PLAN_QUIESCE
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e            kind;
    logic [ADDR_IN_W-1:0]  addr;
    salc_mode_e            mode;
    salc_reg_e             field_sel;
    logic [CFG_DATA_W-1:0] value;
  } plan_item_t;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               eviction;
    logic               last;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } outcome_t;

  // Block ports
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [ADDR_IN_W-1:0]  address_i   = '0;
  logic [MODE_W-1:0]     mode_i      = MODE_LOAD;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_SET_INDEX_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  done_o;
  logic                  hit_o;
  logic                  miss_o;
  logic                  eviction_o;
  logic [TOTAL_W-1:0]    total_hits_o;
  logic [TOTAL_W-1:0]    total_misses_o;
  logic [TOTAL_W-1:0]    total_evictions_o;
  logic                  last_of_item_o;

  // Planned transactions and predicted results
  plan_item_t plan_q[$];
  outcome_t   outcome_q[$];

  // Bench copy of the cache: per-line valid, tag and recency rank (0 = newest)
  logic                 way_valid [LINE_COUNT];
  logic [ADDR_IN_W-1:0] way_tag   [LINE_COUNT];
  logic [2:0]           way_rank  [LINE_COUNT];
  logic [TOTAL_W-1:0]   hit_tally;
  logic [TOTAL_W-1:0]   miss_tally;
  logic [TOTAL_W-1:0]   evict_count;
  logic [SETB_CFG_W-1:0] cfg_set_bits;
  logic [WAYS_CFG_W-1:0] cfg_ways;
  logic [OFFS_CFG_W-1:0] cfg_offset;

  // Stimulus planning state: register values as planned, and a tag pool
  int                   plan_set_bits = 4;
  int                   plan_ways     = 1;
  int                   plan_offset   = 4;
  int                   eff_set_bits  = 4;
  logic [ADDR_IN_W-1:0] tag_pool [16];
  int                   pool_n        = 1;
  int                   planned_accesses = 0;

  // Driver pacing
  int burst_left  = 1;
  int gap_left    = 0;
  int settle_cnt  = 0;
  int quiet_cycles = 0;
  int fault_count  = 0;

  set_assoc_lru_cache_model_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .address_i        (address_i),
    .mode_i           (mode_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .miss_o           (miss_o),
    .eviction_o       (eviction_o),
    .total_hits_o     (total_hits_o),
    .total_misses_o   (total_misses_o),
    .total_evictions_o(total_evictions_o),
    .last_of_item_o   (last_of_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    fault_count++;
  endtask

  // One lookup in the bench cache; queue the result it gives.
  task automatic cache_lookup(input logic [ADDR_IN_W-1:0] addr, input logic last_flag);
    int                   sb;
    int                   nw;
    int                   base;
    int                   found;
    int                   empty;
    int                   victim;
    int                   fill;
    logic [ADDR_IN_W-1:0] set_no;
    logic [ADDR_IN_W-1:0] tag_v;
    logic [2:0]           rank;
    outcome_t             r;
    sb = (cfg_set_bits > SET_CAP) ? SET_CAP : cfg_set_bits;
    nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_CAP) ? WAY_CAP : cfg_ways);
    // Shifts of 64 or more clear the value, so a wide offset leaves tag 0
    set_no = (addr >> cfg_offset) & ((64'd1 << sb) - 64'd1);
    tag_v  = addr >> (cfg_offset + sb);
    base   = int'(set_no) * WAY_CAP;
    found  = -1;
    empty  = -1;
    victim = 0;
    for (int w = 0; w < nw; w++) begin
      if (way_valid[base + w] && found < 0 && way_tag[base + w] == tag_v) found = w;
      if (!way_valid[base + w] && empty < 0) empty = w;
      // Oldest way wins; ties keep the lowest-numbered way
      if (way_rank[base + w] > way_rank[base + victim]) victim = w;
    end
    r = '0;
    if (found >= 0) begin
      rank = way_rank[base + found];
      r.hit = 1'b1;
      for (int w = 0; w < nw; w++) begin
        if (way_valid[base + w] && way_rank[base + w] < rank && way_rank[base + w] != 3'd7)
          way_rank[base + w]++;
      end
      way_rank[base + found] = 3'd0;
      if (hit_tally != TOTAL_MAX) hit_tally++;
    end else begin
      fill = (empty >= 0) ? empty : victim;
      r.miss     = 1'b1;
      r.eviction = (empty < 0);
      // Age every other valid line in use, saturating at the top rank
      for (int w = 0; w < nw; w++) begin
        if (way_valid[base + w] && w != fill && way_rank[base + w] != 3'd7)
          way_rank[base + w]++;
      end
      way_valid[base + fill] = 1'b1;
      way_tag[base + fill]   = tag_v;
      way_rank[base + fill]  = 3'd0;
      if (miss_tally != TOTAL_MAX) miss_tally++;
      if (r.eviction && evict_count != TOTAL_MAX) evict_count++;
    end
    r.last      = last_flag;
    r.hits      = hit_tally;
    r.misses    = miss_tally;
    r.evictions = evict_count;
    outcome_q.push_back(r);
  endtask

  task automatic push_access(input logic [ADDR_IN_W-1:0] addr, input salc_mode_e mode);
    plan_item_t it;
    it           = '0;
    it.kind      = PLAN_ACCESS;
    it.addr      = addr;
    it.mode      = mode;
    plan_q.push_back(it);
    planned_accesses++;
  endtask

  task automatic push_reg(input salc_reg_e field_sel, input int value);
    plan_item_t it;
    it           = '0;
    it.kind      = PLAN_REG_WRITE;
    it.field_sel = field_sel;
    it.value     = CFG_DATA_W'(value);
    plan_q.push_back(it);
  endtask

  // Wait for the block to go quiet, then rewrite the selected registers.
  task automatic plan_phase(input int sb, input int ways, input int off,
                            input logic [2:0] sel);
    plan_item_t it;
    int         nw;
    it      = '0;
    it.kind = PLAN_QUIESCE;
    plan_q.push_back(it);
    if (sel[0]) begin
      push_reg(REG_SET_INDEX_BITS, sb);
      plan_set_bits = sb;
    end
    if (sel[1]) begin
      push_reg(REG_WAYS_IN_USE, ways);
      plan_ways = ways;
    end
    if (sel[2]) begin
      push_reg(REG_OFFSET_BITS, off);
      plan_offset = off;
    end
    eff_set_bits = (plan_set_bits > SET_CAP) ? SET_CAP : plan_set_bits;
    nw = (plan_ways == 0) ? 1 : ((plan_ways > WAY_CAP) ? WAY_CAP : plan_ways);
    // A few more tags than ways keeps both hits and evictions frequent
    pool_n = nw + $urandom_range(3, 0);
    for (int i = 0; i < pool_n; i++) tag_pool[i] = {$urandom, $urandom};
    if (pool_n > 2) begin
      tag_pool[0] = '0;
      tag_pool[1] = '1;
    end
  endtask

  // Mostly addresses built from the tag pool on a few sets; some fully random.
  function automatic logic [ADDR_IN_W-1:0] pick_address();
    logic [ADDR_IN_W-1:0] low_mask;
    logic [ADDR_IN_W-1:0] set_no;
    int                   sets_n;
    if ($urandom_range(4, 0) == 0) return {$urandom, $urandom};
    sets_n = 1 << eff_set_bits;
    if ($urandom_range(3, 0) == 0) set_no = 64'($urandom_range(sets_n - 1, 0));
    else set_no = 64'($urandom_range((sets_n > 4) ? 3 : sets_n - 1, 0));
    low_mask = (64'd1 << plan_offset) - 64'd1;
    return (tag_pool[$urandom_range(pool_n - 1, 0)] << (plan_offset + eff_set_bits))
         | (set_no << plan_offset) | ({$urandom, $urandom} & low_mask);
  endfunction

  // Driver: retire the transaction that was on the pins, then set up the next.
  always @(posedge clk_i) begin
    plan_item_t head;
    logic       next_start;
    logic       next_we;
    if (!rst_ni) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        way_valid[i] = 1'b0;
        way_tag[i]   = '0;
        way_rank[i]  = 3'd0;
      end
      hit_tally    = '0;
      miss_tally   = '0;
      evict_count  = '0;
      cfg_set_bits = 3'd4;
      cfg_ways     = 4'd1;
      cfg_offset   = 6'd4;
    end else begin
      if (start && !busy) begin
        head = plan_q.pop_front();
        case (head.mode)
          MODE_FETCH: ;
          MODE_MODIFY: begin
            cache_lookup(head.addr, 1'b0);
            cache_lookup(head.addr, 1'b1);
          end
          default: cache_lookup(head.addr, 1'b1);
        endcase
        // At the end of a burst draw a new burst length and a gap, often none
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(8, 1);
        end
      end else if (cfg_we_i) begin
        head = plan_q.pop_front();
        case (head.field_sel)
          REG_SET_INDEX_BITS: cfg_set_bits = head.value[SETB_CFG_W-1:0];
          REG_WAYS_IN_USE:    cfg_ways     = head.value[WAYS_CFG_W-1:0];
          REG_OFFSET_BITS:    cfg_offset   = head.value[OFFS_CFG_W-1:0];
          default: ;
        endcase
      end
      next_start = 1'b0;
      next_we    = 1'b0;
      if (plan_q.size() != 0) begin
        head = plan_q[0];
        case (head.kind)
          PLAN_QUIESCE: begin
            // Hold off until every result is in and the pipe has run dry
            if (outcome_q.size() == 0 && !busy) begin
              if (settle_cnt >= SETTLE_CYCLES) begin
                void'(plan_q.pop_front());
                settle_cnt = 0;
              end else begin
                settle_cnt++;
              end
            end else begin
              settle_cnt = 0;
            end
          end
          PLAN_REG_WRITE: begin
            next_we = 1'b1;
            cfg_idx_i   <= head.field_sel;
            cfg_wdata_i <= head.value;
          end
          default: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              next_start = 1'b1;
              address_i <= head.addr;
              mode_i    <= head.mode;
            end
          end
        endcase
      end
      start    <= next_start;
      cfg_we_i <= next_we;
    end
  end

  // Monitor: every strobe must match the oldest prediction, field by field.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        flag_error("result with nothing expected", 64'({hit_o, miss_o, eviction_o}),
                   64'd0);
      end else begin
        want = outcome_q.pop_front();
        if (hit_o !== want.hit) flag_error("hit", 64'(hit_o), 64'(want.hit));
        if (miss_o !== want.miss) flag_error("miss", 64'(miss_o), 64'(want.miss));
        if (eviction_o !== want.eviction)
          flag_error("eviction", 64'(eviction_o), 64'(want.eviction));
        if (total_hits_o !== want.hits)
          flag_error("total_hits", 64'(total_hits_o), 64'(want.hits));
        if (total_misses_o !== want.misses)
          flag_error("total_misses", 64'(total_misses_o), 64'(want.misses));
        if (total_evictions_o !== want.evictions)
          flag_error("total_evictions", 64'(total_evictions_o), 64'(want.evictions));
        if (last_of_item_o !== want.last)
          flag_error("last_of_item", 64'(last_of_item_o), 64'(want.last));
      end
    end
  end

  // Watchdog: too long without any transaction means the block has hung.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         n;
    int         r;
    int         phase_no;
    salc_mode_e m;
    // Reset settings: 16 sets, one way, 16-byte blocks. Set 0 conflicts on tag.
    push_access(64'h0, MODE_LOAD);
    push_access(64'h0, MODE_LOAD);
    push_access(64'hF, MODE_STORE);
    push_access(64'h100, MODE_LOAD);
    push_access(64'h100, MODE_MODIFY);
    push_access(64'h0, MODE_FETCH);
    push_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_MODIFY);
    push_access(64'h8000_0000_0000_0000, MODE_STORE);
    push_access(64'h0, MODE_LOAD);
    push_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_FETCH);
    // One set, two ways, 2-byte blocks: walk the LRU order
    plan_phase(0, 2, 1, 3'b111);
    push_access(64'h0, MODE_LOAD);
    push_access(64'h2, MODE_LOAD);
    push_access(64'h0, MODE_LOAD);
    push_access(64'h4, MODE_LOAD);
    push_access(64'h2, MODE_STORE);
    push_access(64'h5, MODE_MODIFY);
    // Set bits above the cap, zero ways and an offset that swallows the tag
    plan_phase(7, 0, 63, 3'b111);
    push_access(64'h0, MODE_LOAD);
    push_access(64'h8000_0000_0000_0000, MODE_LOAD);
    push_access(64'h7FFF_FFFF_FFFF_FFFF, MODE_STORE);

    // Random phases: the first few pin register extremes, the rest are drawn
    phase_no = 0;
    while (planned_accesses < ACCESS_TARGET) begin
      case (phase_no)
        0: plan_phase(0, 8, 1, 3'b111);
        1: plan_phase(6, 15, 32, 3'b111);
        2: plan_phase(3, 4, 0, 3'b111);
        3: plan_phase(2, 9, 58, 3'b111);
        default: plan_phase($urandom_range(7, 0),
                            ($urandom_range(4, 0) == 0) ? $urandom_range(15, 0)
                                                        : $urandom_range(8, 1),
                            ($urandom_range(4, 0) == 0) ? $urandom_range(63, 0)
                                                        : $urandom_range(12, 1),
                            $urandom_range(7, 0));
      endcase
      phase_no++;
      n = $urandom_range(90, 30);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(19, 0);
        m = (r < 6) ? MODE_LOAD : (r < 11) ? MODE_STORE : (r < 17) ? MODE_MODIFY : MODE_FETCH;
        push_access(pick_address(), m);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (plan_q.size() != 0 || outcome_q.size() != 0) @(posedge clk_i);
    // Give any stray result time to show up
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
